@@ src/u16u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 encoder core.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	localparam int UNIT_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int MAX_BYTES  = 4;
	localparam int CNT_W      = 3;   // holds 0..MAX_BYTES
	localparam int IDX_W      = 2;   // indexes 0..MAX_BYTES-1
	localparam int LEAD_W     = 10;

	localparam logic [BYTE_W-1:0] REPLACE_BYTE = 8'h3F;   // '?'

	// Encoded result of one code unit, plus the surrogate state to keep
	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [CNT_W-1:0]                 cnt;
		logic                             pair;       // lead + trail combined
		logic                             hold;       // lead kept for next item
		logic [LEAD_W-1:0]                hold_bits;
	} enc_res_t;

endpackage

@@ src/utf16_to_utf8_encoder_core.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_core
// UTF-16 to UTF-8 transcoder: one code unit in, zero to four bytes out.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------
//   input   | in_valid / in_ready | code_unit[15:0], final_unit
//   output  | out_valid/out_ready | out_byte[7:0], run_end, buffer_end
//
// An item is encoded in the cycle it is accepted and loaded into a four-byte
// result register; bytes then leave one per cycle while out_ready is high.
// An item that gives no bytes does not occupy the output.
// The next item is taken in the same cycle as the last byte of the previous.
// A lead surrogate with no bytes is taken whenever in_ready is high.
// Reset clears the held lead and empties the result register.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_core
	import u16u8_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [UNIT_W-1:0]   code_unit,
	input  logic                final_unit,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BYTE_W-1:0]   out_byte,
	output logic                run_end,
	output logic                buffer_end
);

	enc_res_t                         enc;
	logic                             lead_held_q;
	logic [LEAD_W-1:0]                lead_bits_q;
	logic                             busy_q;
	logic [IDX_W-1:0]                 idx_q;
	logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes_s1;
	logic [CNT_W-1:0]                 cnt_s1;
	logic                             fin_s1;
	logic                             last;
	logic                             take_last;
	logic                             in_acc;

	u16u8_encode u_enc (
		.lead_held  (lead_held_q),
		.lead_bits  (lead_bits_q),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.res        (enc)
	);

	// Handshake
	assign last      = (({1'b0, idx_q} + 3'd1) == cnt_s1);
	assign take_last = busy_q & out_ready & last;
	assign in_ready  = ~busy_q | take_last;
	assign in_acc    = in_valid & in_ready;

	assign out_valid  = busy_q;
	assign out_byte   = bytes_s1[idx_q];
	assign run_end    = last;
	assign buffer_end = last & fin_s1;

	// Surrogate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_held_q <= 1'b0;
			lead_bits_q <= '0;
		end else if (in_acc) begin
			lead_held_q <= enc.hold;
			lead_bits_q <= enc.hold ? enc.hold_bits : '0;
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (in_acc) begin
			busy_q <= (enc.cnt != '0);
			idx_q  <= '0;
		end else if (take_last) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (busy_q && out_ready) begin
			idx_q  <= idx_q + 1'b1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			bytes_s1 <= enc.bytes;
			cnt_s1   <= enc.cnt;
			fin_s1   <= final_unit;
		end
	end

	// Checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_s1 != '0) && (cnt_s1 <= CNT_W'(MAX_BYTES)))
		else $error("byte count out of range while busy");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, idx_q} < cnt_s1))
		else $error("byte index beyond count");

	a_pair_four: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && enc.pair) |=> (busy_q && cnt_s1 == CNT_W'(MAX_BYTES)))
		else $error("surrogate pair did not give four bytes");

	a_final_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && final_unit) |=> (busy_q && fin_s1 && !lead_held_q))
		else $error("final unit gave no bytes or left a lead held");

	a_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && enc.hold && !lead_held_q) |=> !busy_q)
		else $error("held lead produced bytes");

endmodule

@@ src/u16u8_encode.sv @@
// ----------------------------------------------------------------------------
// u16u8_encode
// Combinational encoder: one UTF-16 unit and the held lead give up to four
// UTF-8 bytes, in order, and the next surrogate state.
// ----------------------------------------------------------------------------
module u16u8_encode
	import u16u8_pkg::*;
(
	input  logic                lead_held,
	input  logic [LEAD_W-1:0]   lead_bits,
	input  logic [UNIT_W-1:0]   code_unit,
	input  logic                final_unit,
	output enc_res_t            res
);

	logic                     is_sur;
	logic                     is_trail;
	logic                     is_lead;
	logic                     flush;
	logic [20:0]              cp;
	logic [2:0][BYTE_W-1:0]   ub;
	logic [1:0]               ub_cnt;

	// Surrogate classification
	assign is_sur   = (code_unit[15:11] == 5'b11011);
	assign is_trail = is_sur & code_unit[10];
	assign is_lead  = is_sur & ~code_unit[10];
	assign flush    = lead_held & ~is_trail;

	// Supplementary code point from held lead and trail
	assign cp = {1'b0, lead_bits, code_unit[9:0]} + 21'h10000;

	// Bytes for the unit on its own
	always_comb begin
		ub     = '0;
		ub_cnt = 2'd0;
		if (code_unit inside {[16'h0000:16'h007F]}) begin
			ub[0]  = code_unit[7:0];
			ub_cnt = 2'd1;
		end else if (code_unit inside {[16'h0080:16'h07FF]}) begin
			ub[0]  = {3'b110, code_unit[10:6]};
			ub[1]  = {2'b10, code_unit[5:0]};
			ub_cnt = 2'd2;
		end else if (is_sur) begin
			if (is_lead && !final_unit) begin
				ub_cnt = 2'd0;
			end else begin
				ub[0]  = REPLACE_BYTE;
				ub_cnt = 2'd1;
			end
		end else begin
			ub[0]  = {4'b1110, code_unit[15:12]};
			ub[1]  = {2'b10, code_unit[11:6]};
			ub[2]  = {2'b10, code_unit[5:0]};
			ub_cnt = 2'd3;
		end
	end

	// Assemble the byte list
	always_comb begin
		res           = '0;
		res.pair      = lead_held & is_trail;
		res.hold      = is_lead & ~final_unit & ~res.pair;
		res.hold_bits = code_unit[9:0];
		if (res.pair) begin
			res.bytes[0] = {5'b11110, cp[20:18]};
			res.bytes[1] = {2'b10, cp[17:12]};
			res.bytes[2] = {2'b10, cp[11:6]};
			res.bytes[3] = {2'b10, cp[5:0]};
			res.cnt      = CNT_W'(MAX_BYTES);
		end else if (flush) begin
			res.bytes[0] = REPLACE_BYTE;
			res.bytes[1] = ub[0];
			res.bytes[2] = ub[1];
			res.bytes[3] = ub[2];
			res.cnt      = {1'b0, ub_cnt} + 3'd1;
		end else begin
			res.bytes[0] = ub[0];
			res.bytes[1] = ub[1];
			res.bytes[2] = ub[2];
			res.cnt      = {1'b0, ub_cnt};
		end
	end

endmodule

@@ tb/utf16_to_utf8_encoder_core_tb.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_core_tb
// Self-checking bench for the UTF-16 to UTF-8 encoder core. Code units are
// fed from a queue of pending items; every accepted unit is encoded by a
// local transcoder that tracks the held lead surrogate, and each byte that
// leaves the core is compared with the oldest expected byte. Directed corner
// units come first, then random buffers under four sender/receiver idling
// patterns.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_core_tb;
	import u16u8_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct {
		logic [UNIT_W-1:0] unit;
		logic              fin;
	} unit_item_t;

	typedef struct {
		logic [BYTE_W-1:0] octet;
		logic              run_last;
		logic              buf_last;
	} utf8_byte_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [UNIT_W-1:0]   code_unit = '0;
	logic                final_unit = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [BYTE_W-1:0]   out_byte;
	logic                run_end;
	logic                buffer_end;

	unit_item_t  pending_units[$];
	utf8_byte_t  utf8_expected[$];
	unit_item_t  next_item;
	utf8_byte_t  want;

	// transcoder state: lead surrogate waiting for its trail
	logic              lead_waiting = 1'b0;
	logic [LEAD_W-1:0] lead_low10 = '0;

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int          mismatches = 0;
	int          cycle_count = 0;

	utf16_to_utf8_encoder_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.code_unit  (code_unit),
		.final_unit (final_unit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.buffer_end (buffer_end)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Encode one accepted unit and queue the bytes it should produce
	task automatic encode_unit(input logic [UNIT_W-1:0] unit, input logic fin);
		logic [BYTE_W-1:0] enc [MAX_BYTES];
		logic [20:0]       cp;
		logic              is_sur;
		logic              is_trail;
		int                n;
		utf8_byte_t        b;
		n = 0;
		is_sur = (unit[15:11] == 5'b11011);
		is_trail = is_sur && unit[10];
		if (lead_waiting && is_trail) begin
			cp = 21'h10000 + {1'b0, lead_low10, 10'b0} + {11'b0, unit[9:0]};
			lead_waiting = 1'b0;
			lead_low10 = '0;
			enc[0] = {5'b11110, cp[20:18]};
			enc[1] = {2'b10, cp[17:12]};
			enc[2] = {2'b10, cp[11:6]};
			enc[3] = {2'b10, cp[5:0]};
			n = 4;
		end else begin
			// flush an unpaired lead before handling this unit
			if (lead_waiting) begin
				enc[n] = REPLACE_BYTE;
				n++;
				lead_waiting = 1'b0;
				lead_low10 = '0;
			end
			if (unit < 16'h0080) begin
				enc[n] = unit[7:0];
				n++;
			end else if (unit < 16'h0800) begin
				enc[n] = {3'b110, unit[10:6]};
				enc[n+1] = {2'b10, unit[5:0]};
				n += 2;
			end else if (is_sur) begin
				if (!is_trail && !fin) begin
					lead_waiting = 1'b1;
					lead_low10 = unit[9:0];
				end else begin
					enc[n] = REPLACE_BYTE;
					n++;
				end
			end else begin
				enc[n] = {4'b1110, unit[15:12]};
				enc[n+1] = {2'b10, unit[11:6]};
				enc[n+2] = {2'b10, unit[5:0]};
				n += 3;
			end
		end
		for (int i = 0; i < n; i++) begin
			b.octet = enc[i];
			b.run_last = (i == n - 1);
			b.buf_last = (i == n - 1) && fin;
			utf8_expected.push_back(b);
		end
	endtask

	task automatic push_unit(input logic [UNIT_W-1:0] unit, input logic fin);
		unit_item_t it;
		it.unit = unit;
		it.fin = fin;
		pending_units.push_back(it);
	endtask

	// Mostly well-formed buffers, with some lone surrogates and raw noise
	task automatic queue_random_units(input int count);
		int          added;
		int          cps;
		int          pick;
		logic [15:0] wide;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 99) < 80) begin
				cps = $urandom_range(1, 6);
				for (int i = 0; i < cps; i++) begin
					pick = $urandom_range(0, 3);
					case (pick)
						0: begin
							push_unit(16'($urandom_range(0, 16'h007F)), i == cps - 1);
						end
						1: begin
							push_unit(16'($urandom_range(16'h0080, 16'h07FF)), i == cps - 1);
						end
						2: begin
							wide = 16'($urandom_range(16'h0800, 16'hF7FF));
							if (wide >= 16'hD800)
								wide = wide + 16'h0800;
							push_unit(wide, i == cps - 1);
						end
						default: begin
							push_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
							push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), i == cps - 1);
							added++;
						end
					endcase
					added++;
				end
			end else begin
				pick = $urandom_range(0, 2);
				case (pick)
					0: push_unit(16'($urandom), $urandom_range(0, 3) == 0);
					1: push_unit(16'($urandom_range(16'hD800, 16'hDBFF)),
						$urandom_range(0, 3) == 0);
					default: push_unit(16'($urandom_range(16'hDC00, 16'hDFFF)),
						$urandom_range(0, 3) == 0);
				endcase
				added++;
			end
		end
	endtask

	// Driver: present pending items, hold each until accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
			if (!in_valid || in_ready) begin
				if (pending_units.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					next_item = pending_units.pop_front();
					in_valid <= 1'b1;
					code_unit <= next_item.unit;
					final_unit <= next_item.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predict on input accept, check on output accept
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				encode_unit(code_unit, final_unit);
			if (out_valid && out_ready) begin
				if (utf8_expected.size() == 0) begin
					$error("unexpected byte: out_byte %h run_end %b buffer_end %b",
						out_byte, run_end, buffer_end);
					mismatches++;
				end else begin
					want = utf8_expected.pop_front();
					if (out_byte !== want.octet) begin
						$error("out_byte: expected %h, got %h", want.octet, out_byte);
						mismatches++;
					end
					if (run_end !== want.run_last) begin
						$error("run_end: expected %b, got %b", want.run_last, run_end);
						mismatches++;
					end
					if (buffer_end !== want.buf_last) begin
						$error("buffer_end: expected %b, got %b", want.buf_last, buffer_end);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("utf16_to_utf8_encoder_core: mismatch");
		$finish;
	end

	// Stimulus and phase sequencing
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// phase 0: corner units, then random units, no idling
		idle_pct = 0;
		stall_pct = 0;
		push_unit(16'h0000, 1'b0);
		push_unit(16'h007F, 1'b0);
		push_unit(16'h0080, 1'b0);
		push_unit(16'h07FF, 1'b0);
		push_unit(16'h0800, 1'b0);
		push_unit(16'hD7FF, 1'b0);
		push_unit(16'hE000, 1'b0);
		push_unit(16'hFFFF, 1'b1);
		// lowest and highest surrogate pairs, the second one ending the buffer
		push_unit(16'hD800, 1'b0);
		push_unit(16'hDC00, 1'b0);
		push_unit(16'hDBFF, 1'b0);
		push_unit(16'hDFFF, 1'b1);
		// lone trail
		push_unit(16'hDC00, 1'b0);
		// held lead flushed by a two-byte unit
		push_unit(16'hD83D, 1'b0);
		push_unit(16'h07FF, 1'b0);
		// lead flushed by another lead, which then pairs
		push_unit(16'hD801, 1'b0);
		push_unit(16'hDBFF, 1'b0);
		push_unit(16'hDC05, 1'b0);
		// lead at end of buffer
		push_unit(16'hDBFF, 1'b1);
		// flush plus three bytes, final
		push_unit(16'hD800, 1'b0);
		push_unit(16'h0800, 1'b1);
		// flush then final lead
		push_unit(16'hDABC, 1'b0);
		push_unit(16'hD9AA, 1'b1);
		// single byte buffer after a final unit
		push_unit(16'h0041, 1'b1);
		queue_random_units(50);
		while (pending_units.size() != 0 || in_valid) @(negedge clk);

		// phase 1: sender idle most of the time
		idle_pct = 70;
		stall_pct = 0;
		queue_random_units(55);
		while (pending_units.size() != 0 || in_valid) @(negedge clk);

		// phase 2: receiver stalling most of the time
		idle_pct = 0;
		stall_pct = 70;
		queue_random_units(55);
		while (pending_units.size() != 0 || in_valid) @(negedge clk);

		// phase 3: light idling on both sides
		idle_pct = 19;
		stall_pct = 19;
		queue_random_units(55);
		while (pending_units.size() != 0 || in_valid || utf8_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && utf8_expected.size() == 0) begin
			$display("utf16_to_utf8_encoder_core: match");
		end else begin
			$display("utf16_to_utf8_encoder_core: mismatch");
		end
		$finish;
	end

endmodule
